### design/lfo_pkg.sv
// Shared constants, register and waveform codes, and the sine table function of the LFO.
package lfo_pkg;

    localparam int PHASE_BITS_DEF     = 32;
    localparam int OUT_BITS_DEF       = 16;
    localparam int SINE_ADDR_BITS_DEF = 10;

    localparam int APB_ADDR_BITS = 4;
    localparam int APB_DATA_BITS = 32;

    localparam logic [1:0] REG_WAVEFORM_SELECT = 2'd0;
    localparam logic [1:0] REG_PHASE_STEP      = 2'd1;
    localparam logic [1:0] REG_PHASE_START     = 2'd2;
    localparam logic [1:0] REG_SMOOTHING_COEFF = 2'd3;

    localparam logic [2:0] WAVE_SINE      = 3'd0;
    localparam logic [2:0] WAVE_TRIANGLE  = 3'd1;
    localparam logic [2:0] WAVE_SQUARE    = 3'd2;
    localparam logic [2:0] WAVE_RAMP_UP   = 3'd3;
    localparam logic [2:0] WAVE_RAMP_DOWN = 3'd4;

    localparam logic [15:0] SMOOTHING_COEFF_RESET = 16'hFFFF;

    localparam longint unsigned PIO2_Q30 = 64'd1686629713;

    // One entry of the quarter-wave sine table: a Taylor sum in Q30 up to the
    // seventeenth power, rounded to frac_bits and clamped below one.
    function automatic longint sine_entry(input int idx, input int addr_bits,
                                          input int frac_bits);
        longint unsigned x;
        longint unsigned t;
        longint unsigned v;
        longint unsigned maxv;
        longint          sum;
        x = (PIO2_Q30 * 64'(idx)) >> addr_bits;
        t = x;
        sum = longint'(x);
        for (int k = 1; k <= 8; k++) begin
            t = (t * x) >> 30;
            t = (t * x) >> 30;
            unique case (k)
                1: t = t / 64'd6;
                2: t = t / 64'd20;
                3: t = t / 64'd42;
                4: t = t / 64'd72;
                5: t = t / 64'd110;
                6: t = t / 64'd156;
                7: t = t / 64'd210;
                default: t = t / 64'd272;
            endcase
            if ((k % 2) == 1) begin
                sum = sum - longint'(t);
            end else begin
                sum = sum + longint'(t);
            end
        end
        if (sum < 0) begin
            sum = 0;
        end
        v = ((longint'(sum) << frac_bits) + (64'd1 << 29)) >> 30;
        maxv = (64'd1 << frac_bits) - 64'd1;
        return (v > maxv) ? longint'(maxv) : longint'(v);
    endfunction

endpackage

### design/lfo_waveform_generator.sv
// Phase-accumulator LFO with sine table, triangle, square and ramps, and a one-pole smoother.
// Path: an accepted tick item passes the input stage registers, then the output register, to the result channel.
// Throughput: one item per cycle while m_ready does not stall the result channel; the sine table read
// and the smoother multiply each occupy one pipeline stage, and the smoother loop closes through smooth_reg.
// Reset: aresetn is synchronous and active low; it clears the phase, the smoother,
// the pipeline and the registers, and leaves the smoothing coefficient at its maximum.
module lfo_waveform_generator
    import lfo_pkg::*;
#(
    parameter int PHASE_BITS     = PHASE_BITS_DEF,
    parameter int OUT_BITS       = OUT_BITS_DEF,
    parameter int SINE_ADDR_BITS = SINE_ADDR_BITS_DEF
) (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       psel,
    input  logic                       penable,
    input  logic                       pwrite,
    input  logic [APB_ADDR_BITS-1:0]   paddr,
    input  logic [APB_DATA_BITS-1:0]   pwdata,
    output logic [APB_DATA_BITS-1:0]   prdata,
    output logic                       pready,
    input  logic                       s_valid,
    output logic                       s_ready,
    input  logic                       s_restart,
    output logic                       m_valid,
    input  logic                       m_ready,
    output logic signed [OUT_BITS-1:0] m_sample
);

    localparam int F    = OUT_BITS - 1;
    localparam int N    = 1 << SINE_ADDR_BITS;
    localparam int DN   = (PHASE_BITS >= F) ? PHASE_BITS - F : 0;
    localparam int UP   = (PHASE_BITS < F) ? F - PHASE_BITS : 0;
    localparam int W    = PHASE_BITS + 3 + UP;
    localparam int ZW   = OUT_BITS + 1;
    localparam int DW   = OUT_BITS + 2;
    localparam int MW   = DW + 17;
    localparam int RUP  = (PHASE_BITS >= 32) ? PHASE_BITS - 32 : 0;
    localparam int RDN  = (PHASE_BITS < 32) ? 32 - PHASE_BITS : 0;
    localparam int WR   = 32 + RUP;

    localparam logic signed [W-1:0]        ONE_W   = signed'(W'(1) << PHASE_BITS);
    localparam logic signed [W-1:0]        SAT_HI  = signed'((W'(1) << F) - W'(1));
    localparam logic signed [W-1:0]        SAT_LO  = -signed'(W'(1) << F);
    localparam logic signed [ZW-1:0]       SQ_HI   = signed'(ZW'(1) << F);
    localparam logic signed [MW-1:0]       ROUND_C = signed'(MW'(32768));
    localparam logic signed [OUT_BITS-1:0] OUT_MAX = signed'((OUT_BITS'(1) << F) - OUT_BITS'(1));
    localparam logic signed [OUT_BITS-1:0] OUT_MIN = signed'(OUT_BITS'(1) << F);

    function automatic logic signed [OUT_BITS-1:0] sat_out(input logic signed [W-1:0] v);
        logic signed [OUT_BITS-1:0] r;
        if (v > SAT_HI) begin
            r = OUT_MAX;
        end else if (v < SAT_LO) begin
            r = OUT_MIN;
        end else begin
            r = OUT_BITS'(v);
        end
        return r;
    endfunction

    function automatic logic [PHASE_BITS-1:0] reg_to_phase(input logic [31:0] r);
        logic [WR-1:0] t;
        t = WR'(r) << RUP;
        return PHASE_BITS'(t >> RDN);
    endfunction

    // Configuration registers.
    logic [2:0]  waveform_select_reg;
    logic [31:0] phase_step_reg;
    logic [31:0] phase_start_reg;
    logic [15:0] smoothing_coeff_reg;
    logic        cfg_write;

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            waveform_select_reg <= WAVE_SINE;
            phase_step_reg      <= '0;
            phase_start_reg     <= '0;
            smoothing_coeff_reg <= SMOOTHING_COEFF_RESET;
        end else if (cfg_write) begin
            unique case (paddr[3:2])
                REG_WAVEFORM_SELECT: waveform_select_reg <= pwdata[2:0];
                REG_PHASE_STEP:      phase_step_reg      <= pwdata;
                REG_PHASE_START:     phase_start_reg     <= pwdata;
                REG_SMOOTHING_COEFF: smoothing_coeff_reg <= pwdata[15:0];
                default:             ;
            endcase
        end
    end

    always_comb begin
        unique case (paddr[3:2])
            REG_WAVEFORM_SELECT: prdata = APB_DATA_BITS'(waveform_select_reg);
            REG_PHASE_STEP:      prdata = phase_step_reg;
            REG_PHASE_START:     prdata = phase_start_reg;
            REG_SMOOTHING_COEFF: prdata = APB_DATA_BITS'(smoothing_coeff_reg);
            default:             prdata = '0;
        endcase
    end

    // Quarter-wave sine table, N+1 entries, read with a registered output.
    logic [F-1:0] sine_rom [N+1];

    for (genvar gi = 0; gi <= N; gi++) begin : g_sine_rom
        assign sine_rom[gi] = F'(sine_entry(gi, SINE_ADDR_BITS, F));
    end

    // Input stage: phase update and table read.
    logic                      s1_valid_reg;
    logic [PHASE_BITS-1:0]     s1_phase_reg;
    logic                      s1_restart_reg;
    logic [F-1:0]              rom_data_reg;
    logic [PHASE_BITS-1:0]     phase_acc_reg;
    logic [PHASE_BITS-1:0]     phase_cur;
    logic [SINE_ADDR_BITS-1:0] tab_offset;
    logic [SINE_ADDR_BITS:0]   rom_addr;
    logic                      s_accept;
    logic                      out_adv;

    assign phase_cur  = s_restart ? reg_to_phase(phase_start_reg) : phase_acc_reg;
    assign tab_offset = phase_cur[PHASE_BITS-3 -: SINE_ADDR_BITS];
    assign rom_addr   = phase_cur[PHASE_BITS-2]
                        ? (SINE_ADDR_BITS+1)'(N) - {1'b0, tab_offset}
                        : {1'b0, tab_offset};
    assign out_adv    = !m_valid || m_ready;
    assign s_ready    = !s1_valid_reg || out_adv;
    assign s_accept   = s_valid && s_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_acc_reg <= '0;
            s1_valid_reg  <= 1'b0;
        end else begin
            if (s_accept) begin
                phase_acc_reg <= phase_cur + reg_to_phase(phase_step_reg);
            end
            if (s_ready) begin
                s1_valid_reg <= s_valid;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_accept) begin
            s1_phase_reg   <= phase_cur;
            s1_restart_reg <= s_restart;
            rom_data_reg   <= sine_rom[rom_addr];
        end
    end

    // Waveform stage: shaping, smoother and saturation.
    logic signed [W-1:0]        pw_s;
    logic signed [W-1:0]        tri_w;
    logic signed [W-1:0]        ramp_w;
    logic signed [W-1:0]        tri_o;
    logic signed [W-1:0]        ramp_o;
    logic signed [ZW-1:0]       raw_z;
    logic signed [ZW-1:0]       z_cur;
    logic signed [ZW-1:0]       z_new;
    logic signed [DW-1:0]       diff;
    logic signed [MW-1:0]       prod;
    logic signed [MW-1:0]       z_step;
    logic signed [OUT_BITS-1:0] sine_mag;
    logic signed [OUT_BITS-1:0] sample_next;
    logic signed [ZW-1:0]       smooth_next;
    logic signed [ZW-1:0]       smooth_reg;
    logic signed [OUT_BITS-1:0] m_sample_reg;
    logic                       m_valid_reg;
    logic                       smoothed_wave;

    assign pw_s   = signed'(W'(s1_phase_reg));
    assign tri_w  = s1_phase_reg[PHASE_BITS-1]
                    ? ((ONE_W <<< 1) + ONE_W) - (pw_s <<< 2)
                    : (pw_s <<< 2) - ONE_W;
    assign ramp_w = (waveform_select_reg == WAVE_RAMP_UP)
                    ? (pw_s <<< 1) - ONE_W
                    : ONE_W - (pw_s <<< 1);
    assign tri_o  = (tri_w >>> DN) <<< UP;
    assign ramp_o = (ramp_w >>> DN) <<< UP;

    assign raw_z  = (waveform_select_reg == WAVE_SQUARE)
                    ? (s1_phase_reg[PHASE_BITS-1] ? -SQ_HI : SQ_HI)
                    : ZW'(ramp_o);
    assign z_cur  = s1_restart_reg ? '0 : smooth_reg;
    assign diff   = DW'(raw_z) - DW'(z_cur);
    assign prod   = signed'({1'b0, smoothing_coeff_reg}) * diff;
    assign z_step = (prod + ROUND_C) >>> 16;
    assign z_new  = z_cur + ZW'(z_step);

    assign sine_mag = signed'({1'b0, rom_data_reg});
    assign smoothed_wave = (waveform_select_reg == WAVE_SQUARE)
                           || (waveform_select_reg == WAVE_RAMP_UP)
                           || (waveform_select_reg == WAVE_RAMP_DOWN);

    always_comb begin
        unique case (waveform_select_reg)
            WAVE_SINE:      sample_next = s1_phase_reg[PHASE_BITS-1] ? -sine_mag : sine_mag;
            WAVE_TRIANGLE:  sample_next = sat_out(tri_o);
            WAVE_SQUARE,
            WAVE_RAMP_UP,
            WAVE_RAMP_DOWN: sample_next = sat_out(W'(z_new));
            default:        sample_next = '0;
        endcase
        smooth_next = smoothed_wave ? z_new : z_cur;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
            smooth_reg  <= '0;
        end else if (out_adv) begin
            m_valid_reg <= s1_valid_reg;
            if (s1_valid_reg) begin
                smooth_reg <= smooth_next;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (out_adv && s1_valid_reg) begin
            m_sample_reg <= sample_next;
        end
    end

    assign m_valid  = m_valid_reg;
    assign m_sample = m_sample_reg;

    a_stage_to_output: assert property (@(posedge aclk) disable iff (!aresetn)
        (s1_valid_reg && out_adv) |=> m_valid_reg)
        else $error("Item in the waveform stage was not moved to the output register.");

    a_accept_when_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        !s1_valid_reg |-> s_ready)
        else $error("Input refused while the waveform stage is empty.");

    a_phase_advance: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_accept && !s_restart)
        |=> phase_acc_reg == $past(phase_acc_reg + reg_to_phase(phase_step_reg)))
        else $error("Phase did not advance by the step.");

    a_sine_keeps_smoother: assert property (@(posedge aclk) disable iff (!aresetn)
        (out_adv && s1_valid_reg && !s1_restart_reg && waveform_select_reg == WAVE_SINE)
        |=> $stable(smooth_reg))
        else $error("Smoother changed while the sine waveform was selected.");

    a_restart_clears: assert property (@(posedge aclk) disable iff (!aresetn)
        (out_adv && s1_valid_reg && s1_restart_reg && !smoothed_wave)
        |=> smooth_reg == '0)
        else $error("Restart did not clear the smoother.");

endmodule

### sim/tb_top.sv
// Self-checking testbench of the LFO waveform generator with a sample predictor and scoreboard.
`timescale 1ns / 1ps

module tb_top;
    import lfo_pkg::*;

    localparam int     FRAC        = OUT_BITS_DEF - 1;
    localparam int     TO_OUT      = PHASE_BITS_DEF - FRAC;
    localparam int     TAB_N       = 1 << SINE_ADDR_BITS_DEF;
    localparam longint PHASE_ONE   = longint'(1) << PHASE_BITS_DEF;
    localparam longint SAMPLE_MAX  = (longint'(1) << FRAC) - 1;
    localparam longint SAMPLE_MIN  = -(longint'(1) << FRAC);
    localparam int     STALL_LIMIT = 4000;
    localparam int     TICK_TOTAL  = 1850;

    logic                     aclk = 1'b0;
    logic                     aresetn = 1'b0;
    logic                     psel = 1'b0;
    logic                     penable = 1'b0;
    logic                     pwrite = 1'b0;
    logic [APB_ADDR_BITS-1:0] paddr = '0;
    logic [APB_DATA_BITS-1:0] pwdata = '0;
    logic [APB_DATA_BITS-1:0] prdata;
    logic                     pready;
    logic                     s_valid = 1'b0;
    logic                     s_ready;
    logic                     s_restart = 1'b0;
    logic                     m_valid;
    logic                     m_ready = 1'b0;
    logic signed [OUT_BITS_DEF-1:0] m_sample;

    // Shadow of the oscillator state and its registers.
    logic [31:0]        phase_acc;
    logic [31:0]        step_reg;
    logic [31:0]        start_reg;
    logic [2:0]         wave_sel;
    logic [15:0]        smooth_k;
    logic signed [31:0] smooth_z;
    longint             quarter_wave [0:TAB_N];

    logic                           pending_ticks [$];
    logic signed [OUT_BITS_DEF-1:0] expected_samples [$];
    int                             fail_count = 0;
    int                             stall_cycles = 0;
    int                             ticks_queued = 0;
    bit                             calm = 1'b0;

    lfo_waveform_generator dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready),
        .s_valid  (s_valid),
        .s_ready  (s_ready),
        .s_restart(s_restart),
        .m_valid  (m_valid),
        .m_ready  (m_ready),
        .m_sample (m_sample)
    );

    always begin
        #4 aclk = 1'b1;
        #4 aclk = 1'b0;
    end

    // Taylor series of sin up to the seventeenth power in Q30, rounded to the output precision.
    function automatic longint quarter_sine(input int unsigned idx);
        longint unsigned x;
        longint unsigned t;
        longint unsigned v;
        longint          sum;
        x = (64'd1686629713 * idx) >> SINE_ADDR_BITS_DEF;
        t = x;
        sum = longint'(x);
        for (int k = 1; k <= 8; k++) begin
            t = (t * x) >> 30;
            t = (t * x) >> 30;
            t = t / longint'((2 * k) * (2 * k + 1));
            if (k % 2 == 1) begin
                sum = sum - longint'(t);
            end else begin
                sum = sum + longint'(t);
            end
        end
        if (sum < 0) begin
            sum = 0;
        end
        v = ((longint'(sum) << FRAC) + (64'd1 << 29)) >> 30;
        return (v > SAMPLE_MAX) ? SAMPLE_MAX : longint'(v);
    endfunction

    function automatic longint clip(input longint v);
        return (v > SAMPLE_MAX) ? SAMPLE_MAX : ((v < SAMPLE_MIN) ? SAMPLE_MIN : v);
    endfunction

    // Advances the shadow oscillator by one tick and returns the sample it gives.
    function automatic logic signed [OUT_BITS_DEF-1:0] next_sample(input logic restart);
        longint      ph;
        longint      raw;
        longint      z;
        longint      m;
        longint      v;
        int unsigned a;
        logic [1:0]  q;
        if (restart) begin
            phase_acc = start_reg;
            smooth_z = '0;
        end
        ph = longint'(phase_acc);
        v = 0;
        case (wave_sel)
            WAVE_SINE: begin
                q = phase_acc[31:30];
                a = phase_acc[29:30-SINE_ADDR_BITS_DEF];
                m = q[0] ? quarter_wave[TAB_N - a] : quarter_wave[a];
                v = q[1] ? -m : m;
            end
            WAVE_TRIANGLE: begin
                v = clip((phase_acc[31] ? 3 * PHASE_ONE - 4 * ph : 4 * ph - PHASE_ONE) >>> TO_OUT);
            end
            WAVE_SQUARE, WAVE_RAMP_UP, WAVE_RAMP_DOWN: begin
                if (wave_sel == WAVE_SQUARE) begin
                    raw = phase_acc[31] ? SAMPLE_MIN : -SAMPLE_MIN;
                end else if (wave_sel == WAVE_RAMP_UP) begin
                    raw = (2 * ph - PHASE_ONE) >>> TO_OUT;
                end else begin
                    raw = (PHASE_ONE - 2 * ph) >>> TO_OUT;
                end
                z = longint'(smooth_z);
                z = z + ((longint'(smooth_k) * (raw - z) + 32768) >>> 16);
                smooth_z = z[31:0];
                v = clip(z);
            end
            default: v = 0;
        endcase
        phase_acc = phase_acc + step_reg;
        return v[OUT_BITS_DEF-1:0];
    endfunction

    task automatic reg_write(input logic [1:0] idx, input logic [31:0] value);
        @(posedge aclk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(posedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        case (idx)
            REG_WAVEFORM_SELECT: wave_sel = value[2:0];
            REG_PHASE_STEP:      step_reg = value;
            REG_PHASE_START:     start_reg = value;
            REG_SMOOTHING_COEFF: smooth_k = value[15:0];
            default: ;
        endcase
    endtask

    task automatic queue_ticks(input int n, input int restart_pct, input bit lead_restart);
        @(negedge aclk);
        for (int i = 0; i < n; i++) begin
            pending_ticks.push_back((i == 0 && lead_restart) ||
                                    ($urandom_range(0, 99) < restart_pct));
        end
        ticks_queued += n;
    endtask

    task automatic wait_drained();
        do @(negedge aclk);
        while (pending_ticks.size() != 0 || s_valid || expected_samples.size() != 0);
        repeat (3) @(posedge aclk);
    endtask

    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else begin
            if (s_valid && s_ready) begin
                expected_samples.push_back(next_sample(s_restart));
            end
            if (!s_valid || s_ready) begin
                if (pending_ticks.size() != 0 && (calm || $urandom_range(0, 99) >= 31)) begin
                    s_valid   <= 1'b1;
                    s_restart <= pending_ticks.pop_front();
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    always @(posedge aclk) begin
        m_ready <= calm || ($urandom_range(0, 99) >= 31);
    end

    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            if (expected_samples.size() == 0) begin
                fail_count++;
                if (fail_count <= 10) begin
                    $display("sample %0d arrived with no item outstanding", m_sample);
                end
            end else begin
                if (m_sample !== expected_samples[0]) begin
                    fail_count++;
                    if (fail_count <= 10) begin
                        $display("sample mismatch: expected %0d, got %0d",
                                 expected_samples[0], m_sample);
                    end
                end
                void'(expected_samples.pop_front());
            end
        end
    end

    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready)) begin
            stall_cycles <= 0;
        end else if (stall_cycles >= STALL_LIMIT) begin
            $display("TEST FAILED");
            $finish;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
    end

    initial begin
        int          phase_no;
        int          n;
        logic [2:0]  sel;
        logic [31:0] value;
        for (int i = 0; i <= TAB_N; i++) begin
            quarter_wave[i] = quarter_sine(i);
        end
        phase_acc = '0;
        smooth_z  = '0;
        wave_sel  = WAVE_SINE;
        step_reg  = '0;
        start_reg = '0;
        smooth_k  = SMOOTHING_COEFF_RESET;
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;

        // Sine at the four quadrant boundaries, with junk above the selector bits.
        reg_write(REG_WAVEFORM_SELECT, {29'h1FFF_FFFF, WAVE_SINE});
        reg_write(REG_PHASE_STEP, 32'h4000_0000);
        queue_ticks(5, 0, 1'b1);
        wait_drained();

        // Triangle either side of the half-cycle point and across the wrap.
        reg_write(REG_WAVEFORM_SELECT, {29'd0, WAVE_TRIANGLE});
        reg_write(REG_PHASE_STEP, 32'h8000_0000);
        reg_write(REG_PHASE_START, 32'h7FFF_FFFF);
        queue_ticks(3, 0, 1'b1);
        wait_drained();

        // Square at the largest smoothing coefficient, then back-to-back restarts.
        reg_write(REG_WAVEFORM_SELECT, {29'd0, WAVE_SQUARE});
        reg_write(REG_SMOOTHING_COEFF, 32'hFFFF_FFFF);
        reg_write(REG_PHASE_START, 32'h0000_0000);
        queue_ticks(3, 0, 1'b1);
        queue_ticks(2, 100, 1'b0);
        wait_drained();

        reg_write(REG_WAVEFORM_SELECT, {29'd0, WAVE_RAMP_UP});
        reg_write(REG_PHASE_START, 32'hFFFF_FFFF);
        reg_write(REG_PHASE_STEP, 32'h4000_0000);
        queue_ticks(3, 0, 1'b1);
        wait_drained();

        // Ramp down with the smoother frozen.
        reg_write(REG_WAVEFORM_SELECT, {29'd0, WAVE_RAMP_DOWN});
        reg_write(REG_SMOOTHING_COEFF, 32'h0000_0000);
        queue_ticks(2, 0, 1'b1);
        wait_drained();

        reg_write(REG_WAVEFORM_SELECT, 32'd5);
        queue_ticks(1, 0, 1'b1);
        wait_drained();
        reg_write(REG_WAVEFORM_SELECT, 32'd7);
        queue_ticks(1, 0, 1'b0);
        wait_drained();

        phase_no = 0;
        while (ticks_queued < TICK_TOTAL) begin
            sel = ($urandom_range(0, 19) < 2) ? 3'($urandom_range(5, 7))
                                              : 3'($urandom_range(0, 4));
            reg_write(REG_WAVEFORM_SELECT, ($urandom & ~32'h7) | {29'd0, sel});
            if ($urandom_range(0, 3) != 0) begin
                case ($urandom_range(0, 5))
                    0: begin
                        case ($urandom_range(0, 3))
                            0: value = 32'h0000_0000;
                            1: value = 32'hFFFF_FFFF;
                            2: value = 32'h8000_0000;
                            default: value = 32'h0000_0001;
                        endcase
                    end
                    1, 2, 3: value = $urandom >> $urandom_range(4, 24);
                    default: value = $urandom;
                endcase
                reg_write(REG_PHASE_STEP, value);
            end
            if ($urandom_range(0, 3) != 0) begin
                case ($urandom_range(0, 3))
                    0: value = 32'h0000_0000;
                    1: value = 32'hFFFF_FFFF;
                    default: value = $urandom;
                endcase
                reg_write(REG_PHASE_START, value);
            end
            if ($urandom_range(0, 3) != 0) begin
                case ($urandom_range(0, 4))
                    0: value = ($urandom & 32'hFFFF_0000) | 32'h0000_FFFF;
                    1: value = $urandom & 32'hFFFF_0000;
                    2: value = 32'h0000_0001;
                    default: value = $urandom >> $urandom_range(0, 12);
                endcase
                reg_write(REG_SMOOTHING_COEFF, value);
            end
            n = $urandom_range(20, 100);
            if (phase_no == 4) begin
                calm = 1'b1;
                n = 250;
            end
            if (phase_no == 2) begin
                // The sender holds off until every outstanding sample has come back.
                queue_ticks(n / 2, $urandom_range(0, 8), 1'b1);
                wait_drained();
                queue_ticks(n - n / 2, $urandom_range(0, 8), 1'b0);
            end else begin
                queue_ticks(n, $urandom_range(0, 8), $urandom_range(0, 9) < 8);
            end
            wait_drained();
            calm = 1'b0;
            phase_no++;
        end

        repeat (10) @(posedge aclk);
        if (fail_count == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule

### lfo_waveform_generator.f
design/lfo_pkg.sv
design/lfo_waveform_generator.sv
sim/tb_top.sv
